// ===== hdl/fcpw_pkg.sv =====
package fcpw_pkg;

	typedef enum logic [4:0] {
		S_IDLE,
		S_ARD,
		S_ALD,
		S_DMUL,
		S_SQRT,
		S_IRD,
		S_ILD,
		S_JCHK,
		S_JRD,
		S_JLD,
		S_CUT,
		S_DIV,
		S_POLY,
		S_POLYB,
		S_POLYC,
		S_PMUL,
		S_PUPD,
		S_IEND,
		S_SC0,
		S_SC1,
		S_SC2,
		S_SDIV
	} state_t;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_EVAL = 1'b1;

	localparam logic CFG_ATOM_COUNT = 1'b0;
	localparam logic CFG_SHARPNESS  = 1'b1;

	localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
	localparam logic [31:0] THREE_Q30 = 32'hC000_0000;
	localparam logic [63:0] SQRT_BIT0 = 64'h4000_0000_0000_0000;

	localparam logic [5:0] DIV_U_LAST = 6'd29;
	localparam logic [5:0] SCALE_LAST = 6'd47;
	localparam logic [5:0] DMUL_LAST  = 6'd3;

	// |a - b| >> 1 for two signed Q16.16 coordinates
	function automatic logic [31:0] half_mag(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] d;
		logic [32:0] m;
		d = {a[31], a} - {b[31], b};
		m = d[32] ? (33'd0 - d) : d;
		return m[32:1];
	endfunction

endpackage

// ===== hdl/fcpw_mul.sv =====
module fcpw_mul (
	input  logic        clk,
	input  logic [31:0] op_a,
	input  logic [31:0] op_b,
	output logic [63:0] prod_s1
);

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
	end

endmodule

// ===== hdl/fuzzy_cell_point_weight.sv =====
// Channel   Direction  Handshake                 Payload
// command   in         start / busy              action, atom_slot, coord_x/y/z, point_weight
// result    out        done (one-cycle strobe)   kept, new_weight, bad_slot
// config    in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A load transaction never raises busy.
// An evaluate with a bad slot answers on the next cycle.
// A good evaluate holds busy while it runs the shared 32x32 multiplier and the one-bit-per-cycle
// square root and divide loops; a pair that saturates or coincides skips the divide, and an
// owner's cell of 0 skips the final scaling divide. done rises as busy falls. cfg_ready is low
// while busy.
// arst_n resets the sequencer and config (one atom, sharpness 3); the atom table is undefined until loaded.
// The result receiver cannot stall: done is high for exactly one cycle.
module fuzzy_cell_point_weight #(
	parameter int MAX_ATOMS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        action,
	input  logic [3:0]  atom_slot,
	input  logic [31:0] coord_x,
	input  logic [31:0] coord_y,
	input  logic [31:0] coord_z,
	input  logic [47:0] point_weight,
	output logic        done,
	output logic        kept,
	output logic [47:0] new_weight,
	output logic        bad_slot,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data
);

	import fcpw_pkg::*;

	localparam int IDX_W = $clog2(MAX_ATOMS);
	localparam int CNT_W = $clog2(MAX_ATOMS + 1);
	localparam int TOT_W = 30 + CNT_W;

	// control
	state_t state_q, state_d;
	logic done_q, done_d;
	logic [4:0] atom_count_q;
	logic [3:0] sharp_q;

	// atom table and per-point distances
	logic [95:0] pos_mem [MAX_ATOMS];
	logic [31:0] d_mem [MAX_ATOMS];
	logic [95:0] pos_rd_q;
	logic [31:0] d_rd_q;
	logic [IDX_W-1:0] pos_addr, d_addr;

	// datapath
	logic [CNT_W-1:0] n_q, k_q, i_q, j_q, n_eff;
	logic [5:0] it_q;
	logic [3:0] stp_q;
	logic [3:0] owner_q;
	logic [47:0] w_q;
	logic [95:0] opa_q, opb_q;
	logic phase_b_q;
	logic [63:0] sum_q, sq_x_q, sq_res_q, sq_bit_q;
	logic [31:0] di_q, dj_q, dab_q, rem_q;
	logic neg_q;
	logic [30:0] a_q, p_q, own_q;
	logic [TOT_W-1:0] total_q, srem_q;
	logic [54:0] hp_q;
	logic [47:0] xl_q, quo_q;
	logic kept_q, bad_q;
	logic [47:0] nw_q;

	// shared multiplier
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod_s1;

	fcpw_mul u_mul (
		.clk     (clk),
		.op_a    (mul_a),
		.op_b    (mul_b),
		.prod_s1 (prod_s1)
	);

	logic accept, eval_bad;
	logic [64:0] sq_trial;
	logic sq_ge;
	logic [32:0] urem2;
	logic [31:0] num;
	logic [31:0] s_sum;
	logic [30:0] s_val;
	logic [TOT_W:0] srem2;
	logic s_ge;
	logic [78:0] x_full;
	logic [31:0] mag;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = !busy;
	assign done       = done_q;
	assign kept       = kept_q;
	assign new_weight = nw_q;
	assign bad_slot   = bad_q;

	assign n_eff = (32'(atom_count_q) > MAX_ATOMS) ? CNT_W'(MAX_ATOMS) : CNT_W'(atom_count_q);
	assign eval_bad = (32'(atom_slot) >= 32'(n_eff));

	assign sq_trial = {1'b0, sq_res_q} + {1'b0, sq_bit_q};
	assign sq_ge    = ({1'b0, sq_x_q} >= sq_trial);
	assign urem2    = {rem_q, 1'b0};
	assign num      = (di_q < dj_q) ? (dj_q - di_q) : (di_q - dj_q);
	assign s_sum    = neg_q ? ({1'b0, ONE_Q30} + {1'b0, a_q}) : ({1'b0, ONE_Q30} - {1'b0, a_q});
	assign s_val    = s_sum[31:1];
	assign srem2    = {srem_q, xl_q[47]};
	assign s_ge     = (srem2 >= {1'b0, total_q});
	assign x_full   = {hp_q, 24'd0} + {24'd0, prod_s1[54:0]};
	assign mag = (it_q < DMUL_LAST) ?
		half_mag(opa_q[32*it_q[1:0] +: 32], opb_q[32*it_q[1:0] +: 32]) : 32'd0;

	// sequencer: next state, done strobe, multiplier operands, memory addresses
	always_comb begin
		state_d  = state_q;
		done_d   = 1'b0;
		mul_a    = 32'd0;
		mul_b    = 32'd0;
		pos_addr = '0;
		d_addr   = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && action == ACT_EVAL) begin
					if (eval_bad) done_d = 1'b1;
					else state_d = S_ARD;
				end
			end
			S_ARD: begin
				pos_addr = k_q[IDX_W-1:0];
				state_d  = S_ALD;
			end
			S_ALD: state_d = S_DMUL;
			S_DMUL: begin
				mul_a = mag;
				mul_b = mag;
				if (it_q == DMUL_LAST) state_d = S_SQRT;
			end
			S_SQRT: begin
				if (sq_bit_q == 64'd0) begin
					if (phase_b_q) state_d = S_CUT;
					else if (k_q == n_q - CNT_W'(1)) state_d = S_IRD;
					else state_d = S_ARD;
				end
			end
			S_IRD: begin
				pos_addr = i_q[IDX_W-1:0];
				d_addr   = i_q[IDX_W-1:0];
				state_d  = S_ILD;
			end
			S_ILD: state_d = S_JCHK;
			S_JCHK: begin
				if (j_q == n_q) state_d = S_IEND;
				else if (j_q != i_q) state_d = S_JRD;
			end
			S_JRD: begin
				pos_addr = j_q[IDX_W-1:0];
				d_addr   = j_q[IDX_W-1:0];
				state_d  = S_JLD;
			end
			S_JLD: state_d = S_DMUL;
			S_CUT: begin
				if (dab_q == 32'd0 || num >= dab_q) state_d = S_POLY;
				else state_d = S_DIV;
			end
			S_DIV: begin
				if (it_q == DIV_U_LAST) state_d = S_POLY;
			end
			S_POLY: begin
				mul_a = {1'b0, a_q};
				mul_b = {1'b0, a_q};
				if (stp_q == sharp_q) state_d = S_PMUL;
				else state_d = S_POLYB;
			end
			S_POLYB: begin
				mul_a = {1'b0, a_q};
				mul_b = THREE_Q30 - {1'b0, prod_s1[60:30]};
				state_d = S_POLYC;
			end
			S_POLYC: state_d = S_POLY;
			S_PMUL: begin
				mul_a   = {1'b0, p_q};
				mul_b   = {1'b0, s_val};
				state_d = S_PUPD;
			end
			S_PUPD: state_d = S_JCHK;
			S_IEND: begin
				if (i_q == n_q - CNT_W'(1)) state_d = S_SC0;
				else state_d = S_IRD;
			end
			S_SC0: begin
				mul_a = {8'd0, w_q[47:24]};
				mul_b = {1'b0, own_q};
				if (own_q == 31'd0) begin
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_SC1;
				end
			end
			S_SC1: begin
				mul_a   = {8'd0, w_q[23:0]};
				mul_b   = {1'b0, own_q};
				state_d = S_SC2;
			end
			S_SC2: state_d = S_SDIV;
			S_SDIV: begin
				if (it_q == SCALE_LAST) begin
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			done_q       <= 1'b0;
			atom_count_q <= 5'd1;
			sharp_q      <= 4'd3;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_ATOM_COUNT: atom_count_q <= cfg_data;
					CFG_SHARPNESS:  sharp_q      <= cfg_data[3:0];
					default: ;
				endcase
			end
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (accept && action == ACT_LOAD && 32'(atom_slot) < MAX_ATOMS) begin
			pos_mem[IDX_W'(atom_slot)] <= {coord_z, coord_y, coord_x};
		end
		pos_rd_q <= pos_mem[pos_addr];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SQRT && sq_bit_q == 64'd0 && !phase_b_q) begin
			d_mem[k_q[IDX_W-1:0]] <= sq_res_q[31:0];
		end
		d_rd_q <= d_mem[d_addr];
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept && action == ACT_EVAL) begin
					opa_q     <= {coord_z, coord_y, coord_x};
					w_q       <= point_weight;
					owner_q   <= atom_slot;
					n_q       <= n_eff;
					k_q       <= '0;
					i_q       <= '0;
					total_q   <= '0;
					own_q     <= 31'd0;
					phase_b_q <= 1'b0;
					if (eval_bad) begin
						kept_q <= 1'b0;
						nw_q   <= 48'd0;
						bad_q  <= 1'b1;
					end
				end
			end
			S_ARD: ;
			S_ALD: begin
				opb_q <= pos_rd_q;
				it_q  <= 6'd0;
			end
			S_DMUL: begin
				it_q <= it_q + 6'd1;
				if (it_q == 6'd0) sum_q <= 64'd0;
				else sum_q <= sum_q + prod_s1;
				if (it_q == DMUL_LAST) begin
					sq_x_q   <= sum_q + prod_s1;
					sq_res_q <= 64'd0;
					sq_bit_q <= SQRT_BIT0;
				end
			end
			S_SQRT: begin
				if (sq_bit_q == 64'd0) begin
					if (phase_b_q) dab_q <= sq_res_q[31:0];
					else k_q <= k_q + CNT_W'(1);
				end else begin
					if (sq_ge) begin
						sq_x_q   <= sq_x_q - sq_trial[63:0];
						sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
					end else begin
						sq_res_q <= sq_res_q >> 1;
					end
					sq_bit_q <= sq_bit_q >> 2;
				end
			end
			S_IRD: ;
			S_ILD: begin
				opa_q     <= pos_rd_q;
				di_q      <= d_rd_q;
				p_q       <= ONE_Q30;
				j_q       <= '0;
				phase_b_q <= 1'b1;
			end
			S_JCHK: begin
				if (j_q != n_q && j_q == i_q) j_q <= j_q + CNT_W'(1);
			end
			S_JRD: ;
			S_JLD: begin
				opb_q <= pos_rd_q;
				dj_q  <= d_rd_q;
				it_q  <= 6'd0;
			end
			S_CUT: begin
				neg_q <= (di_q < dj_q);
				stp_q <= 4'd0;
				it_q  <= 6'd0;
				rem_q <= num;
				if (dab_q == 32'd0) a_q <= 31'd0;
				else if (num >= dab_q) a_q <= ONE_Q30;
				else a_q <= 31'd0;
			end
			S_DIV: begin
				it_q <= it_q + 6'd1;
				if (urem2 >= {1'b0, dab_q}) begin
					rem_q <= 32'(urem2 - {1'b0, dab_q});
					a_q   <= {a_q[29:0], 1'b1};
				end else begin
					rem_q <= urem2[31:0];
					a_q   <= {a_q[29:0], 1'b0};
				end
			end
			S_POLY: ;
			S_POLYB: ;
			S_POLYC: begin
				a_q   <= prod_s1[61:31];
				stp_q <= stp_q + 4'd1;
			end
			S_PMUL: ;
			S_PUPD: begin
				p_q <= prod_s1[60:30];
				j_q <= j_q + CNT_W'(1);
			end
			S_IEND: begin
				total_q <= total_q + TOT_W'(p_q);
				if (32'(i_q) == 32'(owner_q)) own_q <= p_q;
				i_q <= i_q + CNT_W'(1);
			end
			S_SC0: begin
				if (own_q == 31'd0) begin
					kept_q <= 1'b0;
					nw_q   <= 48'd0;
					bad_q  <= 1'b0;
				end
			end
			S_SC1: hp_q <= prod_s1[54:0];
			S_SC2: begin
				srem_q <= TOT_W'(x_full[78:48]);
				xl_q   <= x_full[47:0];
				quo_q  <= 48'd0;
				it_q   <= 6'd0;
			end
			S_SDIV: begin
				it_q  <= it_q + 6'd1;
				xl_q  <= {xl_q[46:0], 1'b0};
				quo_q <= {quo_q[46:0], s_ge};
				if (s_ge) srem_q <= TOT_W'(srem2 - {1'b0, total_q});
				else srem_q <= srem2[TOT_W-1:0];
				if (it_q == SCALE_LAST) begin
					kept_q <= 1'b1;
					nw_q   <= {quo_q[46:0], s_ge};
					bad_q  <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	// a result never coexists with an evaluation in flight
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result strobe while busy");

	// a bad slot result carries no weight
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && bad_slot) |-> (!kept && new_weight == 48'd0))
		else $error("bad slot result with weight");

	// busy only rises from an accepted command
	assert property (@(posedge clk) disable iff (!arst_n) $rose(busy) |-> $past(start))
		else $error("busy without start");

endmodule

// ===== test/tb_fuzzy_cell_point_weight.sv =====
`timescale 1ns / 100ps

module tb_fuzzy_cell_point_weight;
	import fcpw_pkg::*;

	localparam int  TABLE_DEPTH = 16;
	localparam int  CYCLE_LIMIT = 3_000_000;
	localparam int  RANDOM_ITEMS = 64;
	localparam logic [63:0] Q30_ONE = 64'd1 << 30;

	// one command transaction
	typedef struct {
		logic        act;
		logic [3:0]  slot;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [47:0] w;
	} point_cmd_t;

	// one result transaction
	typedef struct {
		logic        kept;
		logic [47:0] weight;
		logic        bad;
	} partition_t;

	// directed row: either a register write or a command, with an optional typed answer
	typedef struct {
		bit          is_cfg;
		logic        reg_idx;
		logic [4:0]  reg_val;
		point_cmd_t  cmd;
		bit          typed;
		partition_t  answer;
	} directed_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        action;
	logic [3:0]  atom_slot;
	logic [31:0] coord_x;
	logic [31:0] coord_y;
	logic [31:0] coord_z;
	logic [47:0] point_weight;
	logic        done;
	logic        kept;
	logic [47:0] new_weight;
	logic        bad_slot;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [4:0]  cfg_data;

	fuzzy_cell_point_weight DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .atom_slot(atom_slot),
		.coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
		.point_weight(point_weight),
		.done(done), .kept(kept), .new_weight(new_weight), .bad_slot(bad_slot),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state: its own copy of the atom table and registers
	logic [31:0] atom_pos [TABLE_DEPTH][3];
	logic [4:0]  model_count;
	logic [3:0]  model_steps;

	partition_t  pending_partitions[$];
	partition_t  typed_answers[$];   // typed answer per evaluate, checked beside the predictor
	bit          typed_flags[$];
	int          mismatches;
	int          cycle_count;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// floor of integer square root, bit by bit
	function automatic logic [63:0] int_sqrt(input logic [63:0] x);
		logic [63:0] res;
		logic [63:0] bit_w;
		res = 64'd0;
		bit_w = 64'd1 << 62;
		while (bit_w > x) bit_w = bit_w >> 2;
		while (bit_w != 0) begin
			if (x >= res + bit_w) begin
				x = x - (res + bit_w);
				res = (res >> 1) + bit_w;
			end else begin
				res = res >> 1;
			end
			bit_w = bit_w >> 2;
		end
		return res;
	endfunction

	// distance in units of 2^-15; the sum of squares wraps at 64 bits
	function automatic logic [63:0] pair_distance(input logic [31:0] a[3], input logic [31:0] b[3]);
		logic [63:0] sum;
		longint      d;
		logic [63:0] m;
		sum = 64'd0;
		for (int k = 0; k < 3; k++) begin
			d = longint'($signed(a[k])) - longint'($signed(b[k]));
			m = (d < 0) ? 64'(-d) : 64'(d);
			m = m >> 1;
			sum = sum + m * m;
		end
		return int_sqrt(sum);
	endfunction

	// smoothed cell share s for atom i against atom j, Q1.30
	function automatic logic [63:0] smoothed_share(input logic [63:0] di, input logic [63:0] dj,
			input logic [63:0] dab);
		logic        neg;
		logic [63:0] num;
		logic [63:0] a;
		logic [63:0] a2;
		neg = di < dj;
		num = neg ? dj - di : di - dj;
		if (dab == 0) begin
			a = 64'd0;   // coincident atoms: share is one half
		end else begin
			a = (num << 30) / dab;
			if (a > Q30_ONE) a = Q30_ONE;
		end
		for (int k = 0; k < model_steps; k++) begin
			a2 = (a * a) >> 30;
			a = (a * (3 * Q30_ONE - a2)) >> 31;
		end
		return neg ? (Q30_ONE + a) >> 1 : (Q30_ONE - a) >> 1;
	endfunction

	// floor(w * p / s) in two halves to stay inside 64 bits
	function automatic logic [63:0] scaled_weight(input logic [63:0] w, input logic [63:0] p,
			input logic [63:0] s);
		logic [63:0] t;
		t = (w >> 24) * p;
		return ((t / s) << 24) + (((t % s) << 24) + (w & 64'hFF_FFFF) * p) / s;
	endfunction

	function automatic partition_t predict_partition(input point_cmd_t c);
		partition_t  r;
		int          n;
		logic [31:0] pt[3];
		logic [31:0] pi[3];
		logic [31:0] pj[3];
		logic [63:0] dist_to[TABLE_DEPTH];
		logic [63:0] cell_val[TABLE_DEPTH];
		logic [63:0] total;
		logic [63:0] p;
		n = (model_count > TABLE_DEPTH) ? TABLE_DEPTH : model_count;
		r.kept = 1'b0;
		r.weight = 48'd0;
		r.bad = 1'b0;
		if (c.slot >= n) begin
			r.bad = 1'b1;
			return r;
		end
		pt[0] = c.x; pt[1] = c.y; pt[2] = c.z;
		for (int i = 0; i < n; i++) begin
			for (int k = 0; k < 3; k++) pi[k] = atom_pos[i][k];
			dist_to[i] = pair_distance(pt, pi);
		end
		total = 64'd0;
		for (int i = 0; i < n; i++) begin
			p = Q30_ONE;
			for (int k = 0; k < 3; k++) pi[k] = atom_pos[i][k];
			for (int j = 0; j < n; j++) begin
				if (i != j) begin
					for (int k = 0; k < 3; k++) pj[k] = atom_pos[j][k];
					p = (p * smoothed_share(dist_to[i], dist_to[j], pair_distance(pi, pj))) >> 30;
				end
			end
			cell_val[i] = p;
			total = total + p;
		end
		if (cell_val[c.slot] > 0) begin
			r.kept = 1'b1;
			r.weight = 48'(scaled_weight(64'(c.w), cell_val[c.slot], total));
		end
		return r;
	endfunction

	// command acceptance: update the table or queue the predicted partition
	always @(posedge clk) begin
		point_cmd_t c;
		if (arst_n && start && !busy) begin
			c.act = action; c.slot = atom_slot;
			c.x = coord_x; c.y = coord_y; c.z = coord_z; c.w = point_weight;
			if (c.act == ACT_LOAD) begin
				atom_pos[c.slot][0] = c.x;
				atom_pos[c.slot][1] = c.y;
				atom_pos[c.slot][2] = c.z;
			end else begin
				pending_partitions.push_back(predict_partition(c));
			end
		end
	end

	// result check against the oldest prediction
	always @(posedge clk) begin
		partition_t exp_r;
		partition_t typed_r;
		bit         has_typed;
		if (arst_n && done) begin
			if (pending_partitions.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: kept=%0b weight=%h bad=%0b",
						kept, new_weight, bad_slot);
			end else begin
				exp_r = pending_partitions.pop_front();
				has_typed = typed_flags.size() > 0 ? typed_flags.pop_front() : 1'b0;
				typed_r = typed_answers.size() > 0 ? typed_answers.pop_front() : exp_r;
				if (has_typed && (typed_r.kept !== exp_r.kept
						|| typed_r.weight !== exp_r.weight || typed_r.bad !== exp_r.bad)) begin
					mismatches++;
					if (mismatches <= 10)
						$display("table answer disagrees with predictor: table %0b/%h/%0b",
							typed_r.kept, typed_r.weight, typed_r.bad);
				end
				if (kept !== exp_r.kept || new_weight !== exp_r.weight
						|| bad_slot !== exp_r.bad) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp kept=%0b weight=%h bad=%0b, got %0b %h %0b",
							exp_r.kept, exp_r.weight, exp_r.bad, kept, new_weight, bad_slot);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_fuzzy_cell_point_weight: errors");
			$finish;
		end
	end

	// issue one command transaction; start stays high into the next one unless we idle
	task automatic send_cmd(input point_cmd_t c, input bit may_idle);
		int gap;
		if (may_idle && $urandom_range(0, 99) < 32) begin
			start <= 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(posedge clk);
		end
		if (c.act == ACT_EVAL) begin
			typed_flags.push_back(1'b0);
			typed_answers.push_back('{1'b0, 48'd0, 1'b0});
		end
		start <= 1'b1;
		action <= c.act; atom_slot <= c.slot;
		coord_x <= c.x; coord_y <= c.y; coord_z <= c.z; point_weight <= c.w;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// drain every pending result, then let a load or the tail of the datapath settle
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending_partitions.size() != 0 || busy) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [4:0] val);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == CFG_ATOM_COUNT) model_count = val;
		else model_steps = val[3:0];
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] near_coord();
		// within about +-8.0 so that cells overlap
		return 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
	endfunction

	function automatic point_cmd_t random_cmd(input bit mostly_eval, input int max_slot);
		point_cmd_t c;
		c.act = ($urandom_range(0, 99) < (mostly_eval ? 75 : 30)) ? ACT_EVAL : ACT_LOAD;
		c.slot = 4'($urandom_range(0, max_slot));
		if ($urandom_range(0, 9) < 8) begin
			c.x = near_coord(); c.y = near_coord(); c.z = near_coord();
		end else begin
			c.x = $urandom; c.y = $urandom; c.z = $urandom;
		end
		c.w = {16'($urandom), 32'($urandom)};
		return c;
	endfunction

	function automatic directed_row_t cmd_row(input logic act, input logic [3:0] slot,
			input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
			input logic [47:0] w);
		directed_row_t r;
		r.is_cfg = 1'b0; r.reg_idx = CFG_ATOM_COUNT; r.reg_val = 5'd0;
		r.cmd = '{act, slot, x, y, z, w};
		r.typed = 1'b0;
		r.answer = '{1'b0, 48'd0, 1'b0};
		return r;
	endfunction

	function automatic directed_row_t typed_row(input directed_row_t r, input logic k,
			input logic [47:0] w, input logic b);
		r.typed = 1'b1;
		r.answer = '{k, w, b};
		return r;
	endfunction

	function automatic directed_row_t cfg_row(input logic idx, input logic [4:0] val);
		directed_row_t r;
		r = cmd_row(ACT_LOAD, 4'd0, 32'd0, 32'd0, 32'd0, 48'd0);
		r.is_cfg = 1'b1; r.reg_idx = idx; r.reg_val = val;
		return r;
	endfunction

	directed_row_t directed[$];

	initial begin
		point_cmd_t c;
		int         phase_items;
		int         sent;
		logic [4:0] count_pick;

		start = 1'b0; action = ACT_LOAD; atom_slot = 4'd0;
		coord_x = 32'd0; coord_y = 32'd0; coord_z = 32'd0; point_weight = 48'd0;
		cfg_valid = 1'b0; cfg_index = CFG_ATOM_COUNT; cfg_data = 5'd0;
		mismatches = 0; cycle_count = 0;
		model_count = 5'd1; model_steps = 4'd3;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the whole table first so no evaluate ever reads an unloaded slot
		for (int s = 0; s < TABLE_DEPTH; s++) begin
			c = '{ACT_LOAD, 4'(s), near_coord(), near_coord(), near_coord(), 48'd0};
			send_cmd(c, 1'b0);
		end

		// reset config: one atom, so weight passes through and other slots are bad
		directed.push_back(typed_row(cmd_row(ACT_EVAL, 4'd0, 32'd0, 32'd0, 32'd0,
			48'hFFFF_FFFF_FFFF), 1'b1, 48'hFFFF_FFFF_FFFF, 1'b0));
		directed.push_back(typed_row(cmd_row(ACT_EVAL, 4'd0, 32'h7FFF_FFFF, 32'h8000_0000,
			32'hFFFF_FFFF, 48'd0), 1'b1, 48'd0, 1'b0));
		directed.push_back(typed_row(cmd_row(ACT_EVAL, 4'd1, 32'd0, 32'd0, 32'd0,
			48'd1), 1'b0, 48'd0, 1'b1));
		directed.push_back(typed_row(cmd_row(ACT_EVAL, 4'd15, 32'd0, 32'd0, 32'd0,
			48'd1), 1'b0, 48'd0, 1'b1));
		// coincident atoms in slots 2 and 3, far atoms at opposite corners
		directed.push_back(cmd_row(ACT_LOAD, 4'd2, 32'h0001_0000, 32'h0002_0000, 32'd0, 48'd0));
		directed.push_back(cmd_row(ACT_LOAD, 4'd3, 32'h0001_0000, 32'h0002_0000, 32'd0, 48'd0));
		directed.push_back(cmd_row(ACT_LOAD, 4'd4, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 48'd0));
		directed.push_back(cmd_row(ACT_LOAD, 4'd5, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 48'd0));
		directed.push_back(cfg_row(CFG_ATOM_COUNT, 5'd6));
		directed.push_back(cfg_row(CFG_SHARPNESS, 5'd0));
		directed.push_back(cmd_row(ACT_EVAL, 4'd2, 32'h0001_0000, 32'h0002_0000, 32'd0,
			48'h0001_0000_0000));
		directed.push_back(cmd_row(ACT_EVAL, 4'd4, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 48'hFFFF_FFFF_FFFF));
		directed.push_back(cfg_row(CFG_SHARPNESS, 5'd15));
		directed.push_back(cmd_row(ACT_EVAL, 4'd5, 32'h7000_0000, 32'h7000_0000,
			32'h7000_0000, 48'hFFFF_FFFF_FFFF));
		directed.push_back(cmd_row(ACT_EVAL, 4'd0, 32'd0, 32'd0, 32'd0, 48'h0000_0001_0000));
		// no active atom at all
		directed.push_back(cfg_row(CFG_ATOM_COUNT, 5'd0));
		directed.push_back(typed_row(cmd_row(ACT_EVAL, 4'd0, 32'd0, 32'd0, 32'd0,
			48'd5), 1'b0, 48'd0, 1'b1));
		// full table, sharpness 9, then a count beyond the table
		directed.push_back(cfg_row(CFG_ATOM_COUNT, 5'd16));
		directed.push_back(cfg_row(CFG_SHARPNESS, 5'd9));
		directed.push_back(cmd_row(ACT_EVAL, 4'd15, 32'h0000_8000, 32'hFFFF_8000, 32'd0,
			48'h0000_0100_0000));
		directed.push_back(cfg_row(CFG_ATOM_COUNT, 5'd31));
		directed.push_back(cfg_row(CFG_SHARPNESS, 5'd1));
		directed.push_back(cmd_row(ACT_EVAL, 4'd3, 32'h0001_0000, 32'h0002_0000, 32'd0,
			48'h0000_0100_0000));

		foreach (directed[i]) begin
			if (directed[i].is_cfg) begin
				write_reg(directed[i].reg_idx, directed[i].reg_val);
			end else begin
				send_cmd(directed[i].cmd, 1'b0);
				if (directed[i].typed) begin
					typed_flags[typed_flags.size() - 1] = 1'b1;
					typed_answers[typed_answers.size() - 1] = directed[i].answer;
				end
			end
		end

		// random part: phases of small atom counts, each under fresh settings
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			count_pick = 5'($urandom_range(0, 6));
			write_reg(CFG_ATOM_COUNT, count_pick);
			write_reg(CFG_SHARPNESS, 5'($urandom_range(0, 15)));
			phase_items = $urandom_range(10, 25);
			for (int k = 0; k < phase_items; k++) begin
				// loads only into active slots keep every slot written; noise hits any slot
				c = random_cmd(1'b1, (k % 4 == 0) ? 15 : (count_pick > 0 ? count_pick - 1 : 15));
				// the middle of the run goes without any sender idling
				send_cmd(c, !(sent >= 24 && sent < 54));
				sent++;
			end
		end

		wait_drained();
		repeat (50) @(posedge clk);
		if (mismatches == 0 && pending_partitions.size() == 0) begin
			$display("tb_fuzzy_cell_point_weight: clean");
		end else begin
			$display("tb_fuzzy_cell_point_weight: errors");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/fcpw_pkg.sv
hdl/fcpw_mul.sv
hdl/fuzzy_cell_point_weight.sv
test/tb_fuzzy_cell_point_weight.sv
